// ----- rtl/interval_overlap_histogram_assert.svh -----
// Assertion macros for the interval overlap histogram checker.
// Needs nothing else; included by the checker file.
`ifndef INTERVAL_OVERLAP_HISTOGRAM_ASSERT_SVH
`define INTERVAL_OVERLAP_HISTOGRAM_ASSERT_SVH

// cause in this cycle, consequence in the next
`define IOH_ASSERT_NEXT(lbl, clk, rst, cause, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (conseq)) \
    else $error(msg);

// cause and consequence in the same cycle
`define IOH_ASSERT_NOW(lbl, clk, rst, cause, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |-> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/ioh_pkg.sv -----
// Shared constants and controller/datapath types for the overlap histogram.
// No dependencies.
package ioh_pkg;

  localparam int NUM_BINS = 64;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] CFG_RANGE_MIN   = 2'd0;
  localparam logic [1:0] CFG_RANGE_MAX   = 2'd1;
  localparam logic [1:0] CFG_BIN_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_INDEX_SCALE = 2'd3;

  localparam int SUM_W = 48;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLIP, ST_MAP, ST_IDX, ST_RD, ST_MUL, ST_WR,
    ST_QRD, ST_QABS, ST_QMUL, ST_QOUT
  } state_t;

  typedef struct packed {
    logic load_add;
    logic load_read;
    logic clear;
    logic clip;
    logic bound;
    logic map;
    logic idx;
    logic set_recent;
    logic single_on;
    logic single_off;
    logic ram_rd;
    logic mul;
    logic wr;
    logic inc;
    logic qabs;
    logic qmul;
    logic qout;
  } cmd_t;

  typedef struct packed {
    logic rev;
    logic in_recent;
    logic ab_eq;
    logic ab_gt;
    logic walk_last;
    logic single;
  } status_t;

endpackage

// ----- rtl/ioh_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module ioh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ioh_ctrl.sv -----
// Controller state machine for the overlap histogram.
// Depends on ioh_pkg; drives ioh_dpath through cmd_t, reads status_t.
module ioh_ctrl import ioh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_ADD) begin
            state_next = ST_CLIP;
          end else if (func == FUNC_READ) begin
            state_next = ST_QRD;
          end
        end
      end
      ST_CLIP: state_next = ST_MAP;
      ST_MAP: begin
        if (status.rev) begin
          state_next = ST_IDLE;
        end else if (status.in_recent) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_IDX;
        end
      end
      ST_IDX:  state_next = status.ab_gt ? ST_IDLE : ST_RD;
      ST_RD:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_WR;
      ST_WR:   state_next = (status.single || status.walk_last) ? ST_IDLE : ST_RD;
      ST_QRD:  state_next = ST_QABS;
      ST_QABS: state_next = ST_QMUL;
      ST_QMUL: state_next = ST_QOUT;
      ST_QOUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_add  = (func == FUNC_ADD);
          cmd.load_read = (func == FUNC_READ);
          cmd.clear     = (func == FUNC_CLEAR);
        end
      end
      ST_CLIP: begin
        cmd.clip  = 1'b1;
        cmd.bound = 1'b1;
      end
      ST_MAP: begin
        cmd.map       = 1'b1;
        cmd.single_on = status.in_recent;
      end
      ST_IDX: begin
        cmd.idx        = 1'b1;
        cmd.set_recent = status.ab_eq;
        cmd.single_on  = status.ab_eq;
        cmd.single_off = !status.ab_eq;
      end
      ST_RD: begin
        cmd.ram_rd = 1'b1;
        cmd.bound  = 1'b1;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_WR: begin
        cmd.wr  = 1'b1;
        cmd.inc = !(status.single || status.walk_last);
      end
      ST_QRD:  cmd.ram_rd = 1'b1;
      ST_QABS: cmd.qabs = 1'b1;
      ST_QMUL: cmd.qmul = 1'b1;
      ST_QOUT: cmd.qout = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/ioh_dpath.sv -----
// Datapath for the overlap histogram: config registers, clipping, bin
// mapping, bin walk with read-modify-write, scaled read. Uses ioh_pkg, ioh_ram.
module ioh_dpath import ioh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        window_lo,
  input  logic [31:0]        window_hi,
  input  logic signed [15:0] weight,
  input  logic [5:0]         read_bin,
  input  cmd_t               cmd,
  output status_t            status,
  output logic signed [63:0] bin_value,
  output logic [5:0]         bin_number,
  output logic               result_valid
);

  localparam int BK_W = 32 + BIN_W;
  localparam int BL_W = BK_W + 1;
  localparam int BH_W = BK_W + 2;

  logic [31:0] range_min, range_max, bin_width, index_scale;

  logic [31:0]        lo_r, hi_r, lo_c, hi_c;
  logic signed [15:0] w_r;
  logic [5:0]         rb_r;
  logic               oob_r;
  logic [BIN_W-1:0]   cur_bin, b_r, recent;
  logic [BL_W-1:0]    bl_r;
  logic [BH_W-1:0]    bh_r;
  logic [63:0]        plo, phi;
  logic               lo_max, hi_max, single;
  logic signed [48:0] amt_r;
  logic               neg_r;
  logic [47:0]        m_r;
  logic [63:0]        p1_r, p2_r;
  logic [NUM_BINS-1:0] valid;

  logic [SUM_W-1:0] rdata;
  logic [SUM_W-1:0] wdata;

  logic [BK_W-1:0]  bk;
  logic [BL_W-1:0]  bl_next;
  logic [BH_W-1:0]  bh_next;
  logic [31:0]      kl, kh;
  logic [BIN_W-1:0] a_bin, b_bin;
  logic [BH_W-1:0]  top, bot;
  logic [31:0]      len_walk, len_sel;
  logic signed [SUM_W-1:0] s_old;
  logic signed [49:0]      sum;
  logic [64:0]             p;

  ioh_ram #(.WIDTH(SUM_W), .DEPTH(NUM_BINS)) u_bins (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (cur_bin),
    .wdata (wdata),
    .re    (cmd.ram_rd),
    .raddr (cur_bin),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min   <= 32'd0;
      range_max   <= 32'd4194304;
      bin_width   <= 32'd65536;
      index_scale <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_MIN:   range_min   <= cfg_data;
        CFG_RANGE_MAX:   range_max   <= cfg_data;
        CFG_BIN_WIDTH:   bin_width   <= cfg_data;
        CFG_INDEX_SCALE: index_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // bin bounds for cur_bin
  assign bk      = BK_W'(bin_width) * BK_W'(cur_bin);
  assign bl_next = BL_W'(range_min) + BL_W'(bk);
  assign bh_next = BH_W'(bl_next) + BH_W'(bin_width);

  // position to bin
  assign kl    = plo[63:32];
  assign kh    = phi[63:32];
  assign a_bin = lo_max ? BIN_LAST : ((kl > 32'(BIN_LAST)) ? BIN_LAST : kl[BIN_W-1:0]);
  assign b_bin = hi_max ? BIN_LAST : ((kh > 32'(BIN_LAST)) ? BIN_LAST : kh[BIN_W-1:0]);

  // overlap of the clipped window with the current bin
  assign top      = (bh_r < BH_W'(hi_c)) ? bh_r : BH_W'(hi_c);
  assign bot      = (BH_W'(bl_r) > BH_W'(lo_c)) ? BH_W'(bl_r) : BH_W'(lo_c);
  assign len_walk = (top > bot) ? 32'(top - bot) : 32'd0;
  assign len_sel  = single ? (hi_c - lo_c) : len_walk;

  assign s_old = (valid[cur_bin] && !oob_r) ? $signed(rdata) : '0;
  assign sum   = $signed({{2{s_old[SUM_W-1]}}, s_old}) + $signed({amt_r[48], amt_r});
  always_comb begin
    if (sum > 50'sh0_7FFF_FFFF_FFFF) begin
      wdata = 48'h7FFF_FFFF_FFFF;
    end else if (sum < -50'sh0_8000_0000_0000) begin
      wdata = 48'h8000_0000_0000;
    end else begin
      wdata = sum[SUM_W-1:0];
    end
  end

  assign p = 65'(p1_r) + 65'(p2_r >> 16);

  assign status.rev       = lo_c > hi_c;
  assign status.in_recent = (BL_W'(lo_c) >= bl_r) && (BH_W'(hi_c) <= bh_r);
  assign status.ab_eq     = a_bin == b_bin;
  assign status.ab_gt     = a_bin > b_bin;
  assign status.walk_last = (cur_bin == b_r) || (cur_bin == BIN_LAST);
  assign status.single    = single;

  always_ff @(posedge clk) begin
    if (cmd.load_add || cmd.load_read) begin
      lo_r  <= window_lo;
      hi_r  <= window_hi;
      w_r   <= weight;
      rb_r  <= read_bin;
      oob_r <= cmd.load_read && (32'(read_bin) >= 32'(NUM_BINS));
    end
    if (cmd.clip) begin
      lo_c <= (lo_r < range_min) ? range_min : lo_r;
      hi_c <= (hi_r > range_max) ? range_max : hi_r;
    end
    if (cmd.bound) begin
      bl_r <= bl_next;
      bh_r <= bh_next;
    end
    if (cmd.map) begin
      plo    <= 64'(lo_c - range_min) * 64'(index_scale);
      phi    <= 64'(hi_c - range_min) * 64'(index_scale);
      lo_max <= lo_c == range_max;
      hi_max <= hi_c == range_max;
    end
    if (cmd.single_on) begin
      single <= 1'b1;
    end else if (cmd.single_off) begin
      single <= 1'b0;
    end
    if (cmd.mul) begin
      amt_r <= $signed(w_r) * $signed({1'b0, len_sel});
    end
    if (cmd.qabs) begin
      neg_r <= s_old[SUM_W-1];
      m_r   <= s_old[SUM_W-1] ? 48'(48'd0 - s_old) : s_old;
    end
    if (cmd.qmul) begin
      p1_r <= 64'(m_r) * 64'(index_scale[31:16]);
      p2_r <= 64'(m_r) * 64'(index_scale[15:0]);
    end
    if (cmd.qout) begin
      bin_number <= rb_r;
      if (!neg_r) begin
        bin_value <= (p > 65'h0_7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                     : $signed(p[63:0]);
      end else if (p >= 65'h0_8000_0000_0000_0000) begin
        bin_value <= 64'sh8000_0000_0000_0000;
      end else begin
        bin_value <= $signed(64'd0 - p[63:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bin      <= '0;
      b_r          <= '0;
      recent       <= '0;
      valid        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.qout;
      if (cmd.clear) begin
        valid  <= '0;
        recent <= '0;
      end
      if (cmd.load_add) begin
        cur_bin <= recent;
      end else if (cmd.load_read) begin
        cur_bin <= BIN_W'(read_bin);
      end else if (cmd.idx) begin
        cur_bin <= a_bin;
        b_r     <= b_bin;
      end else if (cmd.inc) begin
        cur_bin <= cur_bin + 1'b1;
      end
      if (cmd.set_recent) begin
        recent <= a_bin;
      end
      if (cmd.wr) begin
        valid[cur_bin] <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/interval_overlap_histogram.sv -----
// Interval overlap histogram, top level: controller plus datapath.
// Uses ioh_pkg, ioh_ctrl, ioh_dpath.
//
// One item at a time; busy is high while an item is in work. A clear is
// done without leaving idle. A read runs from start to the one-cycle
// result_valid strobe through bin RAM read, magnitude, two partial products
// and saturate. An add clips and maps the window, finds the bin range
// unless the window sits in the remembered bin, then for each bin written
// does a RAM read, weight multiply and saturating write, a read-modify-write
// of the bin RAM; a clipped window that is reversed writes no bin.
// The receiver cannot stall results; config is to be written only while
// idle, which the user must ensure; the block itself does not enforce it.
module interval_overlap_histogram import ioh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [31:0]        window_lo,
  input  logic [31:0]        window_hi,
  input  logic signed [15:0] weight,
  input  logic [5:0]         read_bin,
  output logic               result_valid,
  output logic signed [63:0] bin_value,
  output logic [5:0]         bin_number,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cmd_t    cmd;
  status_t status;

  ioh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ioh_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .window_lo    (window_lo),
    .window_hi    (window_hi),
    .weight       (weight),
    .read_bin     (read_bin),
    .cmd          (cmd),
    .status       (status),
    .bin_value    (bin_value),
    .bin_number   (bin_number),
    .result_valid (result_valid)
  );

endmodule

// ----- rtl/ioh_checker.sv -----
// Port-level checker for the interval overlap histogram, bound to the top.
// Uses ioh_pkg and interval_overlap_histogram_assert.svh.
`include "interval_overlap_histogram_assert.svh"

module ioh_checker import ioh_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] func,
  input logic [5:0] read_bin,
  input logic       result_valid,
  input logic [5:0] bin_number
);

  `IOH_ASSERT_NEXT(a_strobe_single, clk, rst, result_valid, !result_valid, "double strobe")
  `IOH_ASSERT_NEXT(a_read_busy, clk, rst, start && !busy && func == FUNC_READ, busy, "read not busy")
  `IOH_ASSERT_NOW(a_strobe_after_busy, clk, rst, result_valid, $past(busy), "stray strobe")
  `IOH_ASSERT_NOW(a_bin_number, clk, rst, result_valid, bin_number == $past(read_bin, 5), "wrong bin")

endmodule

bind interval_overlap_histogram ioh_checker u_ioh_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .func         (func),
  .read_bin     (read_bin),
  .result_valid (result_valid),
  .bin_number   (bin_number)
);
